// ===== hw/rtl/assert_macros.svh =====
// assertion helper macros included by rps_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that a property holds at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// shared types and constants for ranked parent selection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rps_pkg;

  localparam int MAX_POP_DEF = 32;
  localparam int CFG_W       = 7;
  localparam int IDX_W       = 6;
  localparam int SCORE_W     = 32;
  localparam int DRAW_W      = 32;

  // configuration register indexes
  localparam logic CFG_PARENTS        = 1'b0;
  localparam logic CFG_RANDOM_PARENTS = 1'b1;

  localparam logic [CFG_W-1:0] PARENTS_RST = 7'd4;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [DRAW_W-1:0]         shuffle_draw;
    logic [DRAW_W-1:0]         sample_draw;
    logic                      last_item;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] rank_slot;
    logic [IDX_W-1:0] source_index;
    logic             is_parent;
    logic             last_result;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ranked_parent_selection_top.sv =====
// ----------------------------------------------------------------------------
// ranked_parent_selection_top
// loads a population, shuffles, stable sorts by score, fills random parent
// slots and emits the new order one slot per transaction
// ----------------------------------------------------------------------------
// on the last loaded item the sequencer runs the shuffle (a modulo unit
//   division per step), insertion sort (a fetch per member, then compare
//   and shift), random slot fill (candidate scan, then the modulo and
//   swap) and emission (one slot per transaction)
// one population at a time; the next loads once the last result is taken
// reset: synchronous active low, clears control state and the config registers
`timescale 1ns / 1ps
`default_nettype none
module ranked_parent_selection_top #(
  parameter int MAX_POP = rps_pkg::MAX_POP_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  rps_pkg::in_item_t       in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output rps_pkg::out_item_t            out_data,
  input  wire                           cfg_we,
  input  wire                           cfg_index,
  input  wire  [rps_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
  localparam int CW = $clog2(MAX_POP + 1);
  localparam logic [CW-1:0] MAX_N = CW'(MAX_POP);

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_SHUF_MOD, S_SHUF_RD, S_SHUF_WR,
    S_SORT_RD, S_SORT_CMP, S_SORT_WR,
    S_RND_SCAN, S_RND_MOD, S_RND_SEL, S_RND_WR, S_EMIT_RD, S_EMIT
  } state_t;

  // storage
  logic [rps_pkg::SCORE_W-1:0] score_mem  [MAX_POP];
  logic [rps_pkg::DRAW_W-1:0]  shuf_mem   [MAX_POP];
  logic [rps_pkg::DRAW_W-1:0]  samp_mem   [MAX_POP];
  logic [rps_pkg::IDX_W-1:0]   order_mem  [MAX_POP];
  logic [AW-1:0]               cand_mem   [MAX_POP];

  state_t             state_r;
  logic [CW-1:0]      cnt_r;       // loaded count
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      i_r, j_r, k_r;
  logic [CW-1:0]      ccnt_r;
  logic [rps_pkg::CFG_W-1:0] mu_cfg_r, phi_cfg_r;
  logic [CW-1:0]      mu_r;
  logic [rps_pkg::IDX_W-1:0] v_r, t_r;
  logic signed [rps_pkg::SCORE_W-1:0] vs_r;
  logic               out_valid_r;
  rps_pkg::out_item_t out_r;

  // shared restoring modulo unit: rem = dividend % divisor, one bit a cycle
  logic [rps_pkg::DRAW_W-1:0] md_q_r;
  logic [CW:0]                md_rem_r;
  logic [CW-1:0]              md_div_r;
  logic [5:0]                 md_cnt_r;
  logic                       md_busy_r;
  logic [CW:0]                md_sh;
  logic [CW:0]                md_sub;

  assign md_sh  = {md_rem_r[CW-1:0], md_q_r[rps_pkg::DRAW_W-1]};
  assign md_sub = md_sh - {1'b0, md_div_r};

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_cfg_r  <= rps_pkg::PARENTS_RST;
      phi_cfg_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rps_pkg::CFG_PARENTS) mu_cfg_r <= cfg_wdata;
      else phi_cfg_r <= cfg_wdata;
    end
  end

  // memory reads used by the sequencer (registered read data)
  logic [rps_pkg::IDX_W-1:0]   ord_rd_r;
  logic [rps_pkg::SCORE_W-1:0] sc_rd_r;

  wire [CW-1:0] n_m1  = n_r - CW'(1);
  wire [CW-1:0] mu_c  = (int'(mu_cfg_r) < int'(n_r)) ? CW'(mu_cfg_r) : n_r;
  wire [CW-1:0] phi_c = (int'(phi_cfg_r) < int'(mu_c)) ? CW'(phi_cfg_r) : mu_c;
  wire          in_acc  = in_valid && in_ready;
  wire          out_acc = out_valid_r && out_ready;

  assign in_ready  = (state_r == S_LOAD) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer with memory access
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      md_busy_r   <= 1'b0;
    end else begin
      // modulo unit step
      if (md_busy_r) begin
        md_q_r <= {md_q_r[rps_pkg::DRAW_W-2:0], 1'b0};
        md_rem_r <= md_sub[CW] ? md_sh : md_sub;
        md_cnt_r <= md_cnt_r - 6'd1;
        if (md_cnt_r == 6'd1) md_busy_r <= 1'b0;
      end
      if (out_acc && state_r != S_EMIT_RD) out_valid_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (cnt_r < MAX_N) begin
              score_mem[cnt_r[AW-1:0]] <= in_data.score;
              shuf_mem[cnt_r[AW-1:0]]  <= in_data.shuffle_draw;
              samp_mem[cnt_r[AW-1:0]]  <= in_data.sample_draw;
            end
            if (in_data.last_item) begin
              n_r   <= (cnt_r < MAX_N) ? cnt_r + CW'(1) : cnt_r;
              cnt_r <= '0;
              i_r   <= '0;
              state_r <= S_INIT;
            end else if (cnt_r < MAX_N) begin
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        // identity order
        S_INIT: begin
          order_mem[i_r[AW-1:0]] <= rps_pkg::IDX_W'(i_r);
          if (i_r == n_m1) begin
            k_r <= '0;
            if (n_m1 == '0) begin
              i_r <= CW'(1);
              state_r <= S_SORT_RD;
            end else begin
              i_r <= n_m1;
              md_q_r <= shuf_mem[0];
              md_rem_r <= '0;
              md_div_r <= n_r;
              md_cnt_r <= 6'(rps_pkg::DRAW_W);
              md_busy_r <= 1'b1;
              state_r <= S_SHUF_MOD;
            end
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        // wait for draw % (i+1), then read both slots
        S_SHUF_MOD: begin
          if (!md_busy_r) begin
            j_r <= md_rem_r[CW-1:0];
            ord_rd_r <= order_mem[i_r[AW-1:0]];
            state_r <= S_SHUF_RD;
          end
        end
        S_SHUF_RD: begin
          t_r <= order_mem[j_r[AW-1:0]];
          state_r <= S_SHUF_WR;
        end
        S_SHUF_WR: begin
          if (j_r != i_r) order_mem[j_r[AW-1:0]] <= ord_rd_r;
          order_mem[i_r[AW-1:0]] <= t_r;
          if (i_r == CW'(1)) begin
            i_r <= CW'(1);
            state_r <= S_SORT_RD;
          end else begin
            i_r <= i_r - CW'(1);
            k_r <= k_r + CW'(1);
            md_q_r <= shuf_mem[k_r[AW-1:0] + AW'(1)];
            md_rem_r <= '0;
            md_div_r <= i_r;
            md_cnt_r <= 6'(rps_pkg::DRAW_W);
            md_busy_r <= 1'b1;
            state_r <= S_SHUF_MOD;
          end
        end
        // insertion sort: fetch v = order[i]
        S_SORT_RD: begin
          if (i_r >= n_r) begin
            mu_r <= mu_c;
            i_r  <= (phi_c == '0) ? '0 : mu_c - phi_c;
            j_r  <= mu_c - phi_c;
            ccnt_r <= '0;
            state_r <= (phi_c == '0) ? S_EMIT_RD : S_RND_SCAN;
          end else begin
            v_r  <= order_mem[i_r[AW-1:0]];
            vs_r <= score_mem[order_mem[i_r[AW-1:0]][AW-1:0]];
            j_r  <= i_r;
            ord_rd_r <= order_mem[i_r[AW-1:0] - AW'(1)];
            state_r <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          sc_rd_r <= score_mem[ord_rd_r[AW-1:0]];
          state_r <= S_SORT_WR;
        end
        S_SORT_WR: begin
          if ($signed(vs_r) > $signed(sc_rd_r)) begin
            order_mem[j_r[AW-1:0]] <= ord_rd_r;
            j_r <= j_r - CW'(1);
            if (j_r == CW'(1)) begin
              order_mem[0] <= v_r;
              i_r <= i_r + CW'(1);
              state_r <= S_SORT_RD;
            end else begin
              ord_rd_r <= order_mem[j_r[AW-1:0] - AW'(2)];
              state_r <= S_SORT_CMP;
            end
          end else begin
            order_mem[j_r[AW-1:0]] <= v_r;
            i_r <= i_r + CW'(1);
            state_r <= S_SORT_RD;
          end
        end
        // collect positive candidates from slot i upward
        S_RND_SCAN: begin
          if (j_r < n_r) begin
            if (!score_mem[order_mem[j_r[AW-1:0]][AW-1:0]][rps_pkg::SCORE_W-1] &&
                score_mem[order_mem[j_r[AW-1:0]][AW-1:0]] != '0) begin
              cand_mem[ccnt_r[AW-1:0]] <= j_r[AW-1:0];
              ccnt_r <= ccnt_r + CW'(1);
            end
            j_r <= j_r + CW'(1);
          end else begin
            md_q_r <= samp_mem[i_r[AW-1:0]];
            md_rem_r <= '0;
            md_div_r <= (ccnt_r == '0) ? n_r - i_r : ccnt_r;
            md_cnt_r <= 6'(rps_pkg::DRAW_W);
            md_busy_r <= 1'b1;
            state_r <= S_RND_MOD;
          end
        end
        S_RND_MOD: begin
          if (!md_busy_r) begin
            if (ccnt_r == '0) j_r <= i_r + md_rem_r[CW-1:0];
            else j_r <= CW'(cand_mem[md_rem_r[AW-1:0]]);
            ord_rd_r <= order_mem[i_r[AW-1:0]];
            state_r <= S_RND_SEL;
          end
        end
        S_RND_SEL: begin
          t_r <= order_mem[j_r[AW-1:0]];
          state_r <= S_RND_WR;
        end
        S_RND_WR: begin
          if (j_r != i_r) order_mem[j_r[AW-1:0]] <= ord_rd_r;
          order_mem[i_r[AW-1:0]] <= t_r;
          ccnt_r <= '0;
          if (i_r + CW'(1) >= mu_r) begin
            i_r <= '0;
            state_r <= S_EMIT_RD;
          end else begin
            i_r <= i_r + CW'(1);
            j_r <= i_r + CW'(1);
            state_r <= S_RND_SCAN;
          end
        end
        // emit one slot per transaction
        S_EMIT_RD: begin
          if (!out_valid_r || out_acc) begin
            out_r.rank_slot    <= rps_pkg::IDX_W'(i_r);
            out_r.source_index <= order_mem[i_r[AW-1:0]];
            out_r.is_parent    <= (int'(i_r) < int'(mu_cfg_r));
            out_r.last_result  <= (i_r == n_m1);
            out_valid_r <= 1'b1;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (i_r == n_m1) state_r <= S_LOAD;
          else begin
            i_r <= i_r + CW'(1);
            state_r <= S_EMIT_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rps_checker.sv =====
// ----------------------------------------------------------------------------
// rps_checker
// port-level checks on ranked parent selection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rps_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input wire rps_pkg::out_item_t out_data
);

  // no intake while a result is pending
  `ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid, "intake during emission")
  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped")
  // a result that follows an accepted non-last one is not slot zero
  `ASSERT_CLK(a_slot_seq, clk, rst_n, out_valid && out_ready && !out_data.last_result ##1 out_valid |-> out_data.rank_slot != '0, "slot order broken")

endmodule
bind ranked_parent_selection_top rps_checker u_rps_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
